// ===== rtl/core/epoch_seconds_to_date_time_top_macros.svh =====
// Assertion macros for the epoch seconds to date/time block.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef EPOCH_SECONDS_TO_DATE_TIME_TOP_MACROS_SVH
`define EPOCH_SECONDS_TO_DATE_TIME_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define ESTDT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("estdt assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ESTDT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("estdt assertion failed");
`else
`define ESTDT_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define ESTDT_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/estdt_pkg.sv =====
// Package: constants, types and tables of the epoch seconds to date/time block.
`default_nettype none
package estdt_pkg;

	// pipeline depth, accept to result register
	localparam int NUM_STAGES = 11;

	// seconds per day = 675 << 7; floor(2^32 / 675)
	localparam logic [22:0] DAY_RECIP    = 23'd6362914;
	localparam logic [9:0]  DAY_DIV_ODD  = 10'd675;
	// floor(rem / 3600) = (rem * 37283) >> 27 for rem < 86400
	localparam logic [15:0] HOUR_RECIP   = 16'd37283;
	// floor(rem / 60) = (rem * 279621) >> 24 for rem < 86400
	localparam logic [18:0] MIN_RECIP    = 19'd279621;
	// floor(doe / 1460) = (doe * 367720) >> 29 for doe < 146097
	localparam logic [18:0] Q1460_RECIP  = 19'd367720;
	// floor(t / 365) = (t * 183860) >> 26 for t < 146097
	localparam logic [17:0] YEAR_RECIP   = 18'd183860;
	// floor(v / 153) = (v * 1714) >> 18 for v < 1832
	localparam logic [10:0] MONTH_RECIP  = 11'd1714;

	// days from 1600-03-01 (era 4 base) to 1970-01-01
	localparam logic [17:0] DOE_BIAS     = 18'd135080;
	localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
	localparam logic [17:0] DAYS_PER_CEN = 18'd36524;
	localparam logic [11:0] ERA4_YEAR    = 12'd1600;
	localparam logic [11:0] ERA5_YEAR    = 12'd2000;

	localparam logic [16:0] ZONE_RESET   = 17'd7200;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] valid;
	} pipe_ctrl_t;

	// first day of month mp (0 = March) within a March-based year
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/estdt_if.sv =====
// Stream interfaces: timestamp input channel and date/time result channel.
`default_nettype none
interface estdt_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface estdt_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic        out_of_range;

	modport source (output valid, output year, output month, output day_of_month,
		output hour, output minute, output second, output out_of_range, input ready);
	modport sink   (input valid, input year, input month, input day_of_month,
		input hour, input minute, input second, input out_of_range, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/epoch_seconds_to_date_time_top.sv =====
// Top level: pipelined Unix seconds to Gregorian date and time-of-day converter.
//
// Usage
//   in_ch  : valid/ready stream of epoch_seconds (unsigned seconds since
//            1970-01-01 00:00:00 UTC). An item is taken when valid and ready.
//   out_ch : valid/ready stream of year, month, day_of_month, hour, minute,
//            second and out_of_range, one result item per input item, in order.
//   cfg    : cfg_wr_en / cfg_wr_data write the signed 17-bit zone offset that
//            is added before conversion. Write only while the block is idle.
//   If the shifted count is negative or exceeds 32 bits, out_of_range is set
//   and the date and time fields are zero.
// Timing
//   11 register stages, ending in the result register that drives out_ch.
//   One item per cycle sustained while out_ch takes results; the depth is set
//   by the reciprocal multiplies (day, hour, minute, 4-year-cycle, year and
//   month splits), each followed by a register; hour and minute share one.
//   When out_ch stalls, the pipeline holds and fills its bubbles; in_ch ready
//   drops only once every stage holds an item. Nothing is lost or repeated.
// Reset
//   arst_n clears all valid bits and loads the zone offset with +7200 s.
`default_nettype none
`include "epoch_seconds_to_date_time_top_macros.svh"
module epoch_seconds_to_date_time_top
	import estdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [16:0]       cfg_wr_data,
	estdt_in_if.sink          in_ch,
	estdt_out_if.source       out_ch
);

	pipe_ctrl_t ctrl;
	logic [16:0] zone_offset_q;

	// ---------------- configuration register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_offset_q <= ZONE_RESET;
		end else if (cfg_wr_en) begin
			zone_offset_q <= cfg_wr_data;
		end
	end

	// ---------------- pipeline control ----------------
	estdt_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.ctrl      (ctrl)
	);

	assign in_ch.ready  = ctrl.load[0];
	assign out_ch.valid = ctrl.valid[NUM_STAGES-1];

	// ---------------- stage 1: apply zone offset ----------------
	// 34-bit signed sum: bit 33 set means negative, bit 32 set means above 32 bits
	logic [33:0] shifted_w;
	logic [31:0] secs_s1;
	logic        oor_s1;

	assign shifted_w = {2'b00, in_ch.epoch_seconds} + {{17{zone_offset_q[16]}}, zone_offset_q};

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			secs_s1 <= shifted_w[31:0];
			oor_s1  <= shifted_w[33] | shifted_w[32];
		end
	end

	// ---------------- stage 2: day estimate ----------------
	// 86400 = 675 << 7; estimate is exact or one low
	logic [47:0] day_prod_w;
	logic [15:0] dayq_s2;
	logic [31:0] secs_s2;
	logic        oor_s2;

	assign day_prod_w = 48'(secs_s1[31:7]) * 48'(DAY_RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			dayq_s2 <= day_prod_w[47:32];
			secs_s2 <= secs_s1;
			oor_s2  <= oor_s1;
		end
	end

	// ---------------- stage 3: back-multiply ----------------
	logic [25:0] dayp_s3;
	logic [15:0] dayq_s3;
	logic [31:0] secs_s3;
	logic        oor_s3;

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			dayp_s3 <= 26'(dayq_s2) * 26'(DAY_DIV_ODD);
			dayq_s3 <= dayq_s2;
			secs_s3 <= secs_s2;
			oor_s3  <= oor_s2;
		end
	end

	// ---------------- stage 4: day correction, seconds of day ----------------
	logic [24:0] day_diff_w;
	logic [10:0] day_rem_w;
	logic        day_fix_w;
	logic [9:0]  day_rem_fixed_w;
	logic [15:0] days_s4;
	logic [16:0] sod_s4;
	logic        oor_s4;

	assign day_diff_w      = secs_s3[31:7] - 25'(dayp_s3);
	assign day_rem_w       = day_diff_w[10:0];
	assign day_fix_w       = day_rem_w >= 11'(DAY_DIV_ODD);
	assign day_rem_fixed_w = day_fix_w ? 10'(day_rem_w - 11'(DAY_DIV_ODD)) : day_rem_w[9:0];

	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			days_s4 <= dayq_s3 + 16'(day_fix_w);
			sod_s4  <= {day_rem_fixed_w, secs_s3[6:0]};
			oor_s4  <= oor_s3;
		end
	end

	// ---------------- stage 5: day of era, hour and minute-of-day ----------------
	logic [17:0] doe_raw_w;
	logic        era5_w;
	logic [31:0] hour_prod_w;
	logic [34:0] mins_prod_w;
	logic [17:0] doe_s5;
	logic        era5_s5;
	logic [4:0]  hour_s5;
	logic [10:0] mins_s5;
	logic [16:0] sod_s5;
	logic        oor_s5;

	assign doe_raw_w   = 18'(days_s4) + DOE_BIAS;
	assign era5_w      = doe_raw_w >= DAYS_PER_ERA;
	assign hour_prod_w = 32'(sod_s4) * 32'(HOUR_RECIP);
	assign mins_prod_w = 35'(sod_s4) * 35'(MIN_RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			doe_s5  <= era5_w ? doe_raw_w - DAYS_PER_ERA : doe_raw_w;
			era5_s5 <= era5_w;
			hour_s5 <= hour_prod_w[31:27];
			mins_s5 <= mins_prod_w[34:24];
			sod_s5  <= sod_s4;
			oor_s5  <= oor_s4;
		end
	end

	// ---------------- stage 6: 4-year and century counts, minute, second ----------------
	logic [36:0] q1460_prod_w;
	logic [6:0]  q1460_s6;
	logic [2:0]  cent_s6;
	logic        last_day_s6;
	logic [17:0] doe_s6;
	logic        era5_s6;
	logic [4:0]  hour_s6;
	logic [5:0]  minute_s6;
	logic [5:0]  second_s6;
	logic        oor_s6;

	assign q1460_prod_w = 37'(doe_s5) * 37'(Q1460_RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.load[5]) begin
			q1460_s6    <= q1460_prod_w[35:29];
			cent_s6     <= 3'(doe_s5 >= DAYS_PER_CEN) + 3'(doe_s5 >= 18'(2 * DAYS_PER_CEN)) +
				3'(doe_s5 >= 18'(3 * DAYS_PER_CEN)) + 3'(doe_s5 >= 18'(4 * DAYS_PER_CEN));
			last_day_s6 <= doe_s5 == 18'(4 * DAYS_PER_CEN);
			doe_s6      <= doe_s5;
			era5_s6     <= era5_s5;
			hour_s6     <= hour_s5;
			minute_s6   <= 6'(mins_s5 - 11'(hour_s5) * 11'd60);
			second_s6   <= 6'(sod_s5 - 17'(mins_s5) * 17'd60);
			oor_s6      <= oor_s5;
		end
	end

	// ---------------- stage 7: leap-corrected day count ----------------
	logic [17:0] tdays_s7;
	logic [17:0] doe_s7;
	logic        era5_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  minute_s7;
	logic [5:0]  second_s7;
	logic        oor_s7;

	always_ff @(posedge clk) begin
		if (ctrl.load[6]) begin
			tdays_s7  <= doe_s6 - 18'(q1460_s6) + 18'(cent_s6) - 18'(last_day_s6);
			doe_s7    <= doe_s6;
			era5_s7   <= era5_s6;
			hour_s7   <= hour_s6;
			minute_s7 <= minute_s6;
			second_s7 <= second_s6;
			oor_s7    <= oor_s6;
		end
	end

	// ---------------- stage 8: year of era ----------------
	logic [35:0] yoe_prod_w;
	logic [8:0]  yoe_s8;
	logic [17:0] doe_s8;
	logic        era5_s8;
	logic [4:0]  hour_s8;
	logic [5:0]  minute_s8;
	logic [5:0]  second_s8;
	logic        oor_s8;

	assign yoe_prod_w = 36'(tdays_s7) * 36'(YEAR_RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.load[7]) begin
			yoe_s8    <= yoe_prod_w[34:26];
			doe_s8    <= doe_s7;
			era5_s8   <= era5_s7;
			hour_s8   <= hour_s7;
			minute_s8 <= minute_s7;
			second_s8 <= second_s7;
			oor_s8    <= oor_s7;
		end
	end

	// ---------------- stage 9: day of March-based year ----------------
	logic [8:0]  yoe_cent_w;
	logic [17:0] year_start_w;
	logic [17:0] doy_full_w;
	logic [8:0]  doy_s9;
	logic [8:0]  yoe_s9;
	logic        era5_s9;
	logic [4:0]  hour_s9;
	logic [5:0]  minute_s9;
	logic [5:0]  second_s9;
	logic        oor_s9;

	assign yoe_cent_w   = 9'(yoe_s8 >= 9'd100) + 9'(yoe_s8 >= 9'd200) + 9'(yoe_s8 >= 9'd300);
	assign year_start_w = 18'(yoe_s8) * 18'd365 + 18'(yoe_s8[8:2]) - 18'(yoe_cent_w);
	assign doy_full_w   = doe_s8 - year_start_w;

	always_ff @(posedge clk) begin
		if (ctrl.load[8]) begin
			doy_s9    <= doy_full_w[8:0];
			yoe_s9    <= yoe_s8;
			era5_s9   <= era5_s8;
			hour_s9   <= hour_s8;
			minute_s9 <= minute_s8;
			second_s9 <= second_s8;
			oor_s9    <= oor_s8;
		end
	end

	// ---------------- stage 10: month index ----------------
	logic [21:0] mp_prod_w;
	logic [3:0]  mp_s10;
	logic [8:0]  doy_s10;
	logic [8:0]  yoe_s10;
	logic        era5_s10;
	logic [4:0]  hour_s10;
	logic [5:0]  minute_s10;
	logic [5:0]  second_s10;
	logic        oor_s10;

	assign mp_prod_w = (22'(doy_s9) * 22'd5 + 22'd2) * 22'(MONTH_RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.load[9]) begin
			mp_s10     <= mp_prod_w[21:18];
			doy_s10    <= doy_s9;
			yoe_s10    <= yoe_s9;
			era5_s10   <= era5_s9;
			hour_s10   <= hour_s9;
			minute_s10 <= minute_s9;
			second_s10 <= second_s9;
			oor_s10    <= oor_s9;
		end
	end

	// ---------------- stage 11: civil fields, result register ----------------
	// January and February belong to the next calendar year
	logic [3:0]  month_w;
	logic [8:0]  dom_w;
	logic [11:0] year_w;

	assign month_w = (mp_s10 < 4'd10) ? mp_s10 + 4'd3 : mp_s10 - 4'd9;
	assign dom_w   = doy_s10 - month_start(mp_s10) + 9'd1;
	assign year_w  = 12'(yoe_s10) + (era5_s10 ? ERA5_YEAR : ERA4_YEAR) +
		12'(month_w <= 4'd2);

	always_ff @(posedge clk) begin
		if (ctrl.load[10]) begin
			out_ch.out_of_range <= oor_s10;
			out_ch.year         <= oor_s10 ? 12'd0 : year_w;
			out_ch.month        <= oor_s10 ? 4'd0 : month_w;
			out_ch.day_of_month <= oor_s10 ? 5'd0 : dom_w[4:0];
			out_ch.hour         <= oor_s10 ? 5'd0 : hour_s10;
			out_ch.minute       <= oor_s10 ? 6'd0 : minute_s10;
			out_ch.second       <= oor_s10 ? 6'd0 : second_s10;
		end
	end

	// ---------------- assertions ----------------
	`ESTDT_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_ch.valid && in_ch.ready, ctrl.valid[0])
	`ESTDT_ASSERT_IMPL(a_oor_zeroes, clk, arst_n, out_ch.valid && out_ch.out_of_range, (out_ch.year == 12'd0) && (out_ch.month == 4'd0) && (out_ch.day_of_month == 5'd0) && (out_ch.hour == 5'd0) && (out_ch.minute == 6'd0) && (out_ch.second == 6'd0))
	`ESTDT_ASSERT_IMPL(a_fields_legal, clk, arst_n, out_ch.valid && !out_ch.out_of_range, (out_ch.month >= 4'd1) && (out_ch.month <= 4'd12) && (out_ch.day_of_month >= 5'd1) && (out_ch.hour <= 5'd23) && (out_ch.minute <= 6'd59) && (out_ch.second <= 6'd59))
	`ESTDT_ASSERT_IMPL(a_year_span, clk, arst_n, out_ch.valid && !out_ch.out_of_range, (out_ch.year >= 12'd1970) && (out_ch.year <= 12'd2106))

endmodule
`default_nettype wire

// ===== rtl/core/estdt_pipe_ctrl.sv =====
// Pipeline control: per-stage valid bits and load enables with stall support.
`default_nettype none
module estdt_pipe_ctrl
	import estdt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_ready,
	output pipe_ctrl_t ctrl
);

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] load_w;
	logic [NUM_STAGES-1:0] prev_w;

	// a stage loads when the receiver takes, or when some stage at or after it is empty
	always_comb begin
		for (int i = 0; i < NUM_STAGES; i++) begin
			load_w[i] = out_ready ||
				((valid_q | ~({NUM_STAGES{1'b1}} << i)) != {NUM_STAGES{1'b1}});
		end
	end

	assign prev_w = {valid_q[NUM_STAGES-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				if (load_w[i]) begin
					valid_q[i] <= prev_w[i];
				end
			end
		end
	end

	assign ctrl.load  = load_w;
	assign ctrl.valid = valid_q;

endmodule
`default_nettype wire

// ===== sim/epoch_seconds_to_date_time_top_tb.sv =====
// Testbench: self-checking stream test of the epoch seconds to date/time converter.
`timescale 1ns / 100ps
`default_nettype none
module epoch_seconds_to_date_time_top_tb
	import estdt_pkg::*;
;

	localparam int     PHASES           = 8;
	localparam int     RANDOM_PER_PHASE = 220;
	localparam int     STALL_LIMIT      = 1000;
	localparam int     MAX_PRINTS       = 100;
	localparam longint SECONDS_PER_DAY  = 86400;
	localparam longint EPOCH_MAX        = 64'hFFFF_FFFF;
	// last day number that still fits in 32 bits of seconds
	localparam int     LAST_DAY         = 49710;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        out_of_range;
	} date_time_t;

	// one outstanding conversion: the timestamp and the date it should give
	typedef struct packed {
		logic [31:0] epoch;
		date_time_t  date;
	} conversion_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic        cfg_wr_en;
	logic [16:0] cfg_wr_data;

	estdt_in_if  in_ch();
	estdt_out_if out_ch();

	epoch_seconds_to_date_time_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [31:0]        pending_epochs[$];  // items waiting for the driver
	conversion_t        expected_dates[$];  // accepted items awaiting their result
	logic signed [16:0] zone_offset;        // our copy of the offset register
	logic signed [16:0] phase_offsets[PHASES];
	bit                 burst_mode;         // both sides run without idling
	bit                 in_taken;           // item on in_ch accepted at last rising edge
	int                 epochs_queued;
	int                 dates_checked;
	int                 mismatch_count;
	int                 stall_cycles;

	function automatic bit leap_year(input int yr);
		return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
	endfunction

	function automatic int month_days(input int yr, input int mo);
		case (mo)
			2: begin
				return leap_year(yr) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	// Local civil date and time for a timestamp under a zone offset.
	// Walks whole years from 1970, then whole months; slow but plainly right.
	function automatic date_time_t civil_time(input logic [31:0] epoch,
		input logic signed [16:0] ofs);
		longint     local_s;
		longint     days;
		int         sod;
		int         yr;
		int         mo;
		date_time_t r;
		r = '0;
		local_s = longint'(epoch) + longint'(ofs);
		// shifted below the epoch or past 32 bits: flag only, fields stay zero
		if (local_s < 0 || local_s > EPOCH_MAX) begin
			r.out_of_range = 1'b1;
			return r;
		end
		days = local_s / SECONDS_PER_DAY;
		sod  = int'(local_s % SECONDS_PER_DAY);
		yr = 1970;
		while (days >= (leap_year(yr) ? 366 : 365)) begin
			days -= leap_year(yr) ? 366 : 365;
			yr++;
		end
		mo = 1;
		while (days >= month_days(yr, mo)) begin
			days -= month_days(yr, mo);
			mo++;
		end
		r.year         = 12'(yr);
		r.month        = 4'(mo);
		r.day_of_month = 5'(days + 1);
		r.hour         = 5'(sod / 3600);
		r.minute       = 6'((sod / 60) % 60);
		r.second       = 6'(sod % 60);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] epoch,
		input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("%0t mismatch %s: epoch %0d offset %0d got %0d want %0d",
				$time, what, epoch, zone_offset, got, want);
	endtask

	task automatic queue_epoch(input logic [31:0] epoch);
		pending_epochs.push_back(epoch);
		epochs_queued++;
	endtask

	// Random timestamp: half uniform, the rest aimed at the range limits
	// and at local midnight so that day, month and year rollovers show up.
	function automatic logic [31:0] random_epoch();
		longint day_start;
		case ($urandom_range(9))
			4, 5: begin
				return $urandom_range(120000);
			end
			6: begin
				return 32'hFFFF_FFFF - $urandom_range(120000);
			end
			7, 8: begin
				day_start = longint'($urandom_range(LAST_DAY)) * SECONDS_PER_DAY;
				case ($urandom_range(3))
					0: day_start += 0;
					1: day_start += 1;
					2: day_start += SECONDS_PER_DAY - 1;
					default: day_start += SECONDS_PER_DAY - 2;
				endcase
				return 32'(day_start - longint'(zone_offset));
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// Block is idle once every queued item has produced its result.
	task automatic wait_for_drain();
		while (dates_checked != epochs_queued)
			@(negedge clk);
	endtask

	// Driver: new item or idle at the falling edge; an unaccepted item is held.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_taken) begin
				if (pending_epochs.size() != 0 && (burst_mode || $urandom_range(99) >= 32)) begin
					in_ch.valid         <= 1'b1;
					in_ch.epoch_seconds <= pending_epochs.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			out_ch.ready <= burst_mode || ($urandom_range(99) >= 32);
		end else begin
			in_ch.valid         <= 1'b0;
			in_ch.epoch_seconds <= '0;
			out_ch.ready        <= 1'b0;
		end
	end

	// Monitor: predicts on input handshakes, checks on output handshakes,
	// and runs the watchdog on cycles where neither side moves an item.
	always @(posedge clk) begin
		conversion_t want;
		date_time_t  got;
		bit          moved;
		if (arst_n) begin
			moved    = 1'b0;
			in_taken = in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready) begin
				want.epoch = in_ch.epoch_seconds;
				want.date  = civil_time(in_ch.epoch_seconds, zone_offset);
				expected_dates.push_back(want);
				moved    = 1'b1;
			end
			if (out_ch.valid && out_ch.ready) begin
				moved = 1'b1;
				got = '{out_ch.year, out_ch.month, out_ch.day_of_month, out_ch.hour,
					out_ch.minute, out_ch.second, out_ch.out_of_range};
				if (expected_dates.size() == 0) begin
					report_mismatch("result with nothing expected", 32'd0, 0, 0);
				end else begin
					want = expected_dates.pop_front();
					if (got.year != want.date.year)
						report_mismatch("year", want.epoch, got.year, want.date.year);
					if (got.month != want.date.month)
						report_mismatch("month", want.epoch, got.month, want.date.month);
					if (got.day_of_month != want.date.day_of_month)
						report_mismatch("day_of_month", want.epoch, got.day_of_month,
							want.date.day_of_month);
					if (got.hour != want.date.hour)
						report_mismatch("hour", want.epoch, got.hour, want.date.hour);
					if (got.minute != want.date.minute)
						report_mismatch("minute", want.epoch, got.minute, want.date.minute);
					if (got.second != want.date.second)
						report_mismatch("second", want.epoch, got.second, want.date.second);
					if (got.out_of_range != want.date.out_of_range)
						report_mismatch("out_of_range", want.epoch, got.out_of_range,
							want.date.out_of_range);
					dates_checked++;
				end
			end
			if (moved) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		cfg_wr_en           = 1'b0;
		cfg_wr_data         = '0;
		zone_offset         = ZONE_RESET;
		burst_mode          = 1'b0;
		// phase 0 runs on the reset value; the rest include both ends of the
		// nominal range and of the 17-bit register, then two random offsets
		phase_offsets[0] = ZONE_RESET;
		phase_offsets[1] = 17'sd0;
		phase_offsets[2] = -17'sd50400;
		phase_offsets[3] = 17'sd50400;
		phase_offsets[4] = 17'h0FFFF;
		phase_offsets[5] = 17'h10000;
		phase_offsets[6] = 17'($urandom_range(100800) - 50400);
		phase_offsets[7] = 17'($urandom_range(100800) - 50400);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				// sender holds off until the pipeline is empty, then the
				// offset changes with nothing in flight
				wait_for_drain();
				@(negedge clk);
				cfg_wr_en   <= 1'b1;
				cfg_wr_data <= phase_offsets[ph];
				@(negedge clk);
				cfg_wr_en   <= 1'b0;
				zone_offset = phase_offsets[ph];
			end
			burst_mode = (ph == 1);

			case (ph)
				0: begin
					// +2 h: epoch, top of range, max in-range and first out-of-range,
					// leap days, non-leap 2100, year end
					queue_epoch(32'd0);
					queue_epoch(32'd1);
					queue_epoch(32'hFFFF_FFFF);
					queue_epoch(32'hFFFF_FFFF - 32'd7200);
					queue_epoch(32'hFFFF_FFFF - 32'd7199);
					queue_epoch(32'd951782400 - 32'd7200);
					queue_epoch(32'd951782400 - 32'd7201);
					queue_epoch(32'd4107542400 - 32'd7201);
					queue_epoch(32'd4107542400 - 32'd7200);
					queue_epoch(32'd946684800 - 32'd7201);
					queue_epoch(32'd4233686400 - 32'd7200);
					queue_epoch(32'd4233686400 - 32'd7200 + 32'd86399);
				end
				1: begin
					queue_epoch(32'd0);
					queue_epoch(32'hFFFF_FFFF);
				end
				2: begin
					// negative offset: start of the epoch drops below zero
					queue_epoch(32'd0);
					queue_epoch(32'd50399);
					queue_epoch(32'd50400);
				end
				3: begin
					queue_epoch(32'hFFFF_FFFF - 32'd50400);
					queue_epoch(32'hFFFF_FFFF - 32'd50399);
				end
				default: begin
				end
			endcase

			repeat (RANDOM_PER_PHASE)
				queue_epoch(random_epoch());
		end

		wait_for_drain();
		repeat (NUM_STAGES * 4) @(posedge clk);
		if (expected_dates.size() != 0)
			report_mismatch("results never delivered", 32'd0, 0, expected_dates.size());

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/estdt_pkg.sv
rtl/core/estdt_if.sv
rtl/core/estdt_pipe_ctrl.sv
rtl/core/epoch_seconds_to_date_time_top.sv
sim/epoch_seconds_to_date_time_top_tb.sv
